// File: rtl/cdcb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdcb_pkg
// Shared types and constants for the content-defined chunk boundary finder:
// cut reason codes, register map and register reset values.
// ----------------------------------------------------------------------------
package cdcb_pkg;

    typedef enum logic [1:0] {
        REASON_NONE   = 2'd0,
        REASON_ANCHOR = 2'd1,
        REASON_MAX    = 2'd2,
        REASON_END    = 2'd3
    } cut_reason_t;

    typedef enum logic [2:0] {
        REG_WINDOW_SIZE  = 3'd0,
        REG_TOP_POWER    = 3'd1,
        REG_MIN_CHUNK    = 3'd2,
        REG_MAX_CHUNK    = 3'd3,
        REG_ANCHOR_BITS  = 3'd4
    } reg_index_t;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    localparam int unsigned FP_W       = 16;
    localparam int unsigned WSIZE_W    = 7;
    localparam int unsigned MINCH_W    = 16;
    localparam int unsigned MAXCH_W    = 17;
    localparam int unsigned ANCHOR_W   = 4;
    localparam int unsigned CHLEN_W    = 17;

    localparam logic [WSIZE_W-1:0]  RST_WINDOW_SIZE = 7'd48;
    localparam logic [FP_W-1:0]     RST_TOP_POWER   = 16'd12033;
    localparam logic [MINCH_W-1:0]  RST_MIN_CHUNK   = 16'd2048;
    localparam logic [MAXCH_W-1:0]  RST_MAX_CHUNK   = 17'd16384;
    localparam logic [ANCHOR_W-1:0] RST_ANCHOR_BITS = 4'd13;

    // low byte of any power of the base 257 modulo 2^16 is always one
    localparam logic [7:0] POW_LOW_BYTE = 8'h01;

endpackage : cdcb_pkg
`default_nettype wire

// File: rtl/cdcb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdcb_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module cdcb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire                                        aclk,
    input  wire                                        we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                           wdata,
    input  wire                                        re,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule : cdcb_ram
`default_nettype wire

// File: rtl/content_defined_chunk_boundary_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// content_defined_chunk_boundary_top
// Content-defined chunk boundary finder with a 16-bit base-257 rolling
// fingerprint; window bytes of the current chunk live in a ring RAM.
//
//   channel   direction  handshake         payload
//   s_        in         s_valid/s_ready   s_data_byte, s_stream_end
//   m_        out        m_valid/m_ready   m_cut, m_cut_reason, m_chunk_length
//   apb       in/out     psel/penable      paddr, pwdata, prdata
//
// one word per cycle sustained while m_ready holds high; ring read at accept,
// then fingerprint update and cut test in stage 1, registered into the output
// register; the fingerprint loop closes in stage 1; a same-cycle ring
// write/read hazard is forwarded
// synchronous active-low reset clears control state and the registers
// a stalled m_ side holds one word in stage 1 and one in the output register
// ----------------------------------------------------------------------------
module content_defined_chunk_boundary_top
    import cdcb_pkg::*;
#(
    parameter int unsigned MAX_WINDOW = 64,
    parameter int unsigned MAX_CHUNK  = 65536
) (
    input  wire                     aclk,
    input  wire                     aresetn,

    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire  [7:0]              s_data_byte,
    input  wire                     s_stream_end,

    output logic                    m_valid,
    input  wire                     m_ready,
    output logic                    m_cut,
    output logic [1:0]              m_cut_reason,
    output logic [CHLEN_W-1:0]      m_chunk_length,

    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [APB_ADDR_W-1:0]   paddr,
    input  wire  [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int unsigned PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned RW = PW + 2;
    localparam int unsigned LW = $clog2(MAX_CHUNK + 1);
    localparam int unsigned CW = (LW > 17) ? LW : 17;

    // configuration registers
    logic [WSIZE_W-1:0]  window_size_reg;
    logic [FP_W-1:0]     top_power_reg;
    logic [MINCH_W-1:0]  min_chunk_reg;
    logic [MAXCH_W-1:0]  max_chunk_reg;
    logic [ANCHOR_W-1:0] anchor_bits_reg;

    logic cfg_wr;

    // stage 1 and output
    logic                s1_valid_reg;
    logic [7:0]          s1_byte_reg;
    logic                s1_end_reg;
    logic                s1_fwd_reg;
    logic [7:0]          s1_fwd_byte_reg;

    logic [FP_W-1:0]     fp_reg;
    logic [FP_W-1:0]     fp_next;
    logic [LW-1:0]       len_reg;
    logic [LW-1:0]       len_next;
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       wr_ptr_next;

    logic                m_valid_reg;
    logic                m_cut_reg;
    cut_reason_t         m_reason_reg;
    logic [CHLEN_W-1:0]  m_len_reg;

    logic                s_accept;
    logic                adv1;

    // clamped settings
    logic [CW-1:0]       ws_ext;
    logic [CW-1:0]       w_c;
    logic [CW-1:0]       emax_ext;
    logic [CW-1:0]       emax_c;
    logic [CW-1:0]       min_ext;
    logic [ANCHOR_W-1:0] bits_c;
    logic [FP_W-1:0]     mask;

    // ring access
    logic [PW-1:0]       wr_ptr_inc;
    logic [PW-1:0]       rd_base;
    logic [RW-1:0]       rd_diff;
    logic [PW-1:0]       rd_addr;
    logic [7:0]          ram_rdata;
    logic [7:0]          old_byte;

    // fingerprint and cut test
    logic [CW-1:0]       cnt_ext;
    logic [CW-1:0]       new_ext;
    logic [CW-1:0]       exp_full;
    logic [FP_W-1:0]     pow;
    logic [23:0]         fill_prod;
    logic [FP_W-1:0]     fp_fill;
    logic [23:0]         drop_prod;
    logic [FP_W-1:0]     drop_neg;
    logic [FP_W-1:0]     slide_sum;
    logic [FP_W-1:0]     fp_slide;
    logic                filling;
    logic [FP_W-1:0]     fp_upd;
    cut_reason_t         reason;
    logic                s1_cut;

    // ------------------------------------------------------------------
    // apb register file
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= RST_WINDOW_SIZE;
            top_power_reg   <= RST_TOP_POWER;
            min_chunk_reg   <= RST_MIN_CHUNK;
            max_chunk_reg   <= RST_MAX_CHUNK;
            anchor_bits_reg <= RST_ANCHOR_BITS;
        end else if (cfg_wr) begin
            case (reg_index_t'(paddr[4:2]))
                REG_WINDOW_SIZE: window_size_reg <= pwdata[WSIZE_W-1:0];
                REG_TOP_POWER:   top_power_reg   <= pwdata[FP_W-1:0];
                REG_MIN_CHUNK:   min_chunk_reg   <= pwdata[MINCH_W-1:0];
                REG_MAX_CHUNK:   max_chunk_reg   <= pwdata[MAXCH_W-1:0];
                REG_ANCHOR_BITS: anchor_bits_reg <= pwdata[ANCHOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index_t'(paddr[4:2]))
            REG_WINDOW_SIZE: prdata = APB_DATA_W'(window_size_reg);
            REG_TOP_POWER:   prdata = APB_DATA_W'(top_power_reg);
            REG_MIN_CHUNK:   prdata = APB_DATA_W'(min_chunk_reg);
            REG_MAX_CHUNK:   prdata = APB_DATA_W'(max_chunk_reg);
            REG_ANCHOR_BITS: prdata = APB_DATA_W'(anchor_bits_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // clamped settings
    // ------------------------------------------------------------------
    always_comb begin
        ws_ext = CW'(window_size_reg);
        if (ws_ext == '0) begin
            w_c = CW'(1);
        end else if (ws_ext > CW'(MAX_WINDOW)) begin
            w_c = CW'(MAX_WINDOW);
        end else begin
            w_c = ws_ext;
        end

        emax_ext = CW'(max_chunk_reg);
        if (emax_ext > CW'(MAX_CHUNK)) begin
            emax_c = CW'(MAX_CHUNK);
        end else begin
            emax_c = emax_ext;
        end

        min_ext = CW'(min_chunk_reg);
        bits_c  = (anchor_bits_reg == '0) ? ANCHOR_W'(1) : anchor_bits_reg;
        mask    = (FP_W'(1) << bits_c) - FP_W'(1);
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign adv1     = s1_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready  = ~s1_valid_reg | adv1;
    assign s_accept = s_valid & s_ready;

    // ------------------------------------------------------------------
    // ring read address for the incoming word
    // ------------------------------------------------------------------
    assign wr_ptr_inc = (wr_ptr_reg == PW'(MAX_WINDOW - 1)) ? '0 : wr_ptr_reg + PW'(1);
    assign rd_base    = adv1 ? wr_ptr_inc : wr_ptr_reg;

    always_comb begin
        rd_diff = RW'(rd_base) + RW'(MAX_WINDOW) - RW'(w_c);
        if (rd_diff >= RW'(MAX_WINDOW)) begin
            rd_diff = rd_diff - RW'(MAX_WINDOW);
        end
        rd_addr = rd_diff[PW-1:0];
    end

    cdcb_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (adv1),
        .waddr (wr_ptr_reg),
        .wdata (s1_byte_reg),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign old_byte = s1_fwd_reg ? s1_fwd_byte_reg : ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (adv1) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_byte_reg     <= s_data_byte;
            s1_end_reg      <= s_stream_end;
            s1_fwd_reg      <= adv1 & (rd_addr == wr_ptr_reg);
            s1_fwd_byte_reg <= s1_byte_reg;
        end
    end

    // ------------------------------------------------------------------
    // fingerprint update and cut test
    // ------------------------------------------------------------------
    always_comb begin
        cnt_ext  = CW'(len_reg);
        new_ext  = cnt_ext + CW'(1);
        filling  = cnt_ext < w_c;

        // 257^e mod 2^16 reduces to 1 + 256*e
        exp_full  = w_c - CW'(1) - cnt_ext;
        pow       = {exp_full[7:0], POW_LOW_BYTE};
        fill_prod = 24'(s1_byte_reg) * 24'(pow);
        fp_fill   = fp_reg + fill_prod[FP_W-1:0];

        drop_prod = 24'(old_byte) * 24'(top_power_reg);
        drop_neg  = FP_W'(0) - drop_prod[FP_W-1:0];
        slide_sum = fp_reg + drop_neg;
        fp_slide  = slide_sum + {slide_sum[7:0], 8'h00} + FP_W'(s1_byte_reg);

        fp_upd = filling ? fp_fill : fp_slide;

        reason = REASON_NONE;
        if (!filling && (new_ext >= min_ext)) begin
            if ((fp_slide & mask) == '0) begin
                reason = REASON_ANCHOR;
            end else if (new_ext >= emax_c) begin
                reason = REASON_MAX;
            end
        end
        if ((reason == REASON_NONE) && (new_ext >= CW'(MAX_CHUNK))) begin
            reason = REASON_MAX;
        end
        if ((reason == REASON_NONE) && s1_end_reg) begin
            reason = REASON_END;
        end
        s1_cut = (reason != REASON_NONE);

        fp_next     = s1_cut ? '0 : fp_upd;
        len_next    = s1_cut ? '0 : LW'(new_ext);
        wr_ptr_next = s1_cut ? '0 : wr_ptr_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fp_reg     <= '0;
            len_reg    <= '0;
            wr_ptr_reg <= '0;
        end else if (adv1) begin
            fp_reg     <= fp_next;
            len_reg    <= len_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv1) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            m_cut_reg    <= s1_cut;
            m_reason_reg <= reason;
            m_len_reg    <= new_ext[CHLEN_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cut          = m_cut_reg;
    assign m_cut_reason   = m_reason_reg;
    assign m_chunk_length = m_len_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_cut_matches_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cut == (m_cut_reason != REASON_NONE)))
        else $error("cut flag disagrees with cut reason");

    a_cut_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv1 && s1_cut) |=> (len_reg == '0 && fp_reg == '0 && wr_ptr_reg == '0))
        else $error("chunk state not cleared after cut");

    a_len_below_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(len_reg) < CW'(MAX_CHUNK))
        else $error("chunk length reached capacity without a cut");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid && !m_ready))
        else $error("input stalled while pipeline has room");

endmodule : content_defined_chunk_boundary_top
`default_nettype wire
